[rtl/assert_macros.svh]
// assertion macros for the checker file artt_chk
// needs a clock and an active-high reset name at each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that holds at every clock edge outside reset
`define AST_HOLD(label, clk, rst, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// same-cycle implication
`define AST_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define AST_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/artt_pkg.sv]
// types and codes for the ack retransmit timeout tracker
// no dependencies; used by every module of the block
`timescale 1ns / 1ps

package artt_pkg;

  localparam int ID_W      = 32;
  localparam int CONN_W    = 8;
  localparam int TIME_W    = 32;
  localparam int S_TDATA_W = 80;
  localparam int M_TDATA_W = 40;

  localparam logic [TIME_W-1:0] TIMEOUT_RESET = 32'd1000;

  // input modes
  localparam logic [1:0] MODE_RX   = 2'd0;
  localparam logic [1:0] MODE_TX   = 2'd1;
  localparam logic [1:0] MODE_TICK = 2'd2;

  // packet status codes
  localparam logic [1:0] ST_REQ = 2'd0;
  localparam logic [1:0] ST_RSP = 2'd1;
  localparam logic [1:0] ST_ACK = 2'd2;

  // result actions
  localparam logic ACT_RESEND = 1'b0;
  localparam logic ACT_ACK    = 1'b1;

  // table select
  localparam logic TBL_PEND = 1'b0;
  localparam logic TBL_OWED = 1'b1;

  typedef logic [1:0] op_t;
  localparam op_t OP_INS  = 2'd0;
  localparam op_t OP_ERS  = 2'd1;
  localparam op_t OP_SCAN = 2'd2;

  // token that walks down a row of cells
  typedef struct packed {
    logic              vld;
    op_t               op;
    logic [ID_W-1:0]   id;
    logic              hc;
    logic [CONN_W-1:0] conn;
    logic [TIME_W-1:0] tstamp;
    logic              matched;
    logic              claimed;
  } tok_t;

  // broadcast that finishes an insert into the claimed free slot
  typedef struct packed {
    logic              en;
    logic              wr;
    logic [ID_W-1:0]   id;
    logic              hc;
    logic [CONN_W-1:0] conn;
    logic [TIME_W-1:0] tstamp;
  } commit_t;

  // firing entry seen by the scan token
  typedef struct packed {
    logic              fire;
    logic [ID_W-1:0]   id;
    logic [CONN_W-1:0] conn;
  } res_t;

endpackage

[rtl/ack_retransmit_timeout_tracker_core.sv]
// Ack / retransmit timeout tracker. Two tables of TABLE_DEPTH slots, each a row of cells
// that a command token walks down one slot per cycle, unless a firing slot finds the
// hold and output stages full: sent requests waiting for an ack and received requests
// we owe an ack for. Receive/send words insert or erase by packet id; a tick word scans
// the pending table then the owed table in slot order and emits one word per valid,
// connected entry older than timeout_ticks, with tlast on the final one. The input is
// held while a walk is in progress; other words are accepted and dropped. No clearing
// pass is needed after reset. Depends on artt_pkg, artt_row and artt_cell.
`timescale 1ns / 1ps

module ack_retransmit_timeout_tracker_core #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  // configuration: timeout_ticks
  input  logic                            cfg_wr_en,
  input  logic [31:0]                     cfg_wr_data,
  // input words
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // packet_id, packet_status, is_retry, has_connection, connection_id, now_time
  input  logic [artt_pkg::S_TDATA_W-1:0]  s_tdata,
  // mode
  input  logic [1:0]                      s_tuser,
  // result words
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // out_packet_id, out_connection_id
  output logic [artt_pkg::M_TDATA_W-1:0]  m_tdata,
  // action
  output logic                            m_tuser,
  output logic                            m_tlast
);
  import artt_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_INJ    = 3'd1;
  localparam logic [2:0] S_RUN    = 3'd2;
  localparam logic [2:0] S_COMMIT = 3'd3;
  localparam logic [2:0] S_FLUSH  = 3'd4;

  logic [2:0]        state, state_next;
  logic [TIME_W-1:0] timeout_ticks;
  tok_t              item;
  logic              sel;
  logic              ins_wr;

  logic              hold_v;
  logic [ID_W-1:0]   hold_id;
  logic [CONN_W-1:0] hold_conn;
  logic              hold_act;

  logic [ID_W-1:0]   out_id;
  logic [CONN_W-1:0] out_conn;
  logic              out_act;
  logic              out_last;

  // input field unpacking
  logic [1:0]        in_mode;
  logic [ID_W-1:0]   in_id;
  logic [1:0]        in_status;
  logic              in_retry;
  logic              in_hc;
  logic [CONN_W-1:0] in_conn;
  logic [TIME_W-1:0] in_now;

  logic              dec_ok;
  op_t               dec_op;
  logic              dec_sel;

  tok_t              tok_inj;
  tok_t              tok_p, tok_o;
  tok_t              tail_p, tail_o, tail_sel;
  res_t              res_p, res_o, res_sel;
  commit_t           cmt_p, cmt_o;

  logic              accept;
  logic              out_free;
  logic              adv_sel;
  logic              exit_row;
  logic              fire_take;
  logic              push_mid;
  logic              push_end;

  assign in_mode   = s_tuser;
  assign in_id     = s_tdata[31:0];
  assign in_status = s_tdata[33:32];
  assign in_retry  = s_tdata[34];
  assign in_hc     = s_tdata[35];
  assign in_conn   = s_tdata[43:36];
  assign in_now    = s_tdata[75:44];

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    dec_ok  = 1'b0;
    dec_op  = OP_SCAN;
    dec_sel = TBL_PEND;
    unique case (in_mode)
      MODE_RX: begin
        if (in_status == ST_REQ) begin
          dec_ok  = 1'b1;
          dec_op  = OP_INS;
          dec_sel = TBL_OWED;
        end else if ((in_status == ST_RSP) || (in_status == ST_ACK)) begin
          dec_ok  = 1'b1;
          dec_op  = OP_ERS;
          dec_sel = TBL_PEND;
        end
      end
      MODE_TX: begin
        if ((in_status == ST_REQ) && !in_retry) begin
          dec_ok  = 1'b1;
          dec_op  = OP_INS;
          dec_sel = TBL_PEND;
        end else if ((in_status == ST_RSP) || (in_status == ST_ACK)) begin
          dec_ok  = 1'b1;
          dec_op  = OP_ERS;
          dec_sel = TBL_OWED;
        end
      end
      MODE_TICK: begin
        dec_ok  = 1'b1;
        dec_op  = OP_SCAN;
        dec_sel = TBL_PEND;
      end
      default: begin
      end
    endcase
  end

  // row handshake
  assign out_free = !m_tvalid || m_tready;
  assign res_sel  = (sel == TBL_OWED) ? res_o  : res_p;
  assign tail_sel = (sel == TBL_OWED) ? tail_o : tail_p;

  // a firing slot stalls the token when both hold and output stages are full
  assign adv_sel   = (state == S_INJ) ||
                     ((state == S_RUN) && (!res_sel.fire || !hold_v || out_free));
  assign exit_row  = (state == S_RUN) && adv_sel && tail_sel.vld;
  assign fire_take = (state == S_RUN) && res_sel.fire && adv_sel;
  assign push_mid  = fire_take && hold_v;
  assign push_end  = (state == S_FLUSH) && hold_v && out_free;

  always_comb begin
    tok_inj     = item;
    tok_inj.vld = (state == S_INJ);
    tok_p       = tok_inj;
    tok_o       = tok_inj;
    tok_p.vld   = tok_inj.vld && (sel == TBL_PEND);
    tok_o.vld   = tok_inj.vld && (sel == TBL_OWED);

    cmt_p.en     = (state == S_COMMIT) && (sel == TBL_PEND);
    cmt_p.wr     = ins_wr;
    cmt_p.id     = item.id;
    cmt_p.hc     = item.hc;
    cmt_p.conn   = item.conn;
    cmt_p.tstamp = item.tstamp;
    cmt_o        = cmt_p;
    cmt_o.en     = (state == S_COMMIT) && (sel == TBL_OWED);
  end

  artt_row #(
    .DEPTH (TABLE_DEPTH)
  ) u_pend (
    .clk     (clk),
    .rst     (rst),
    .adv     (adv_sel && (sel == TBL_PEND)),
    .timeout (timeout_ticks),
    .commit  (cmt_p),
    .tok_in  (tok_p),
    .tail    (tail_p),
    .res     (res_p)
  );

  artt_row #(
    .DEPTH (TABLE_DEPTH)
  ) u_owed (
    .clk     (clk),
    .rst     (rst),
    .adv     (adv_sel && (sel == TBL_OWED)),
    .timeout (timeout_ticks),
    .commit  (cmt_o),
    .tok_in  (tok_o),
    .tail    (tail_o),
    .res     (res_o)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept && dec_ok) begin
          state_next = S_INJ;
        end
      end
      S_INJ: begin
        state_next = S_RUN;
      end
      S_RUN: begin
        if (exit_row) begin
          if (item.op == OP_INS) begin
            state_next = S_COMMIT;
          end else if (item.op == OP_SCAN) begin
            state_next = (sel == TBL_PEND) ? S_INJ : S_FLUSH;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      S_COMMIT: begin
        state_next = S_IDLE;
      end
      S_FLUSH: begin
        if (!hold_v || out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      timeout_ticks <= TIMEOUT_RESET;
      sel           <= TBL_PEND;
      hold_v        <= 1'b0;
      m_tvalid      <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_wr_en) begin
        timeout_ticks <= cfg_wr_data;
      end
      if (accept && dec_ok) begin
        sel <= dec_sel;
      end else if (exit_row && (item.op == OP_SCAN)) begin
        sel <= TBL_OWED;
      end
      if (fire_take) begin
        hold_v <= 1'b1;
      end else if (push_end) begin
        hold_v <= 1'b0;
      end
      if (push_mid || push_end) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && dec_ok) begin
      item.vld     <= 1'b1;
      item.op      <= dec_op;
      item.id      <= in_id;
      item.hc      <= in_hc;
      item.conn    <= in_conn;
      item.tstamp  <= in_now;
      item.matched <= 1'b0;
      item.claimed <= 1'b0;
    end
    if (exit_row) begin
      // write the claimed slot only when no slot already held the id
      ins_wr <= !tail_sel.matched && tail_sel.claimed;
    end
    if (fire_take) begin
      hold_id   <= res_sel.id;
      hold_conn <= res_sel.conn;
      hold_act  <= (sel == TBL_OWED) ? ACT_ACK : ACT_RESEND;
    end
    if (push_mid || push_end) begin
      out_id   <= hold_id;
      out_conn <= hold_conn;
      out_act  <= hold_act;
      out_last <= push_end;
    end
  end

  assign m_tdata = {out_conn, out_id};
  assign m_tuser = out_act;
  assign m_tlast = out_last;

endmodule

[rtl/artt_cell.sv]
// one table slot: entry storage plus the token stage in front of it
// depends on artt_pkg
`timescale 1ns / 1ps

module artt_cell (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     adv,
  input  logic [31:0]              timeout,
  input  artt_pkg::commit_t        commit,
  input  artt_pkg::tok_t           tok_in,
  output artt_pkg::tok_t           tok_out,
  output artt_pkg::res_t           res
);
  import artt_pkg::*;

  tok_t              tok;
  logic              valid;
  logic              cand;
  logic [ID_W-1:0]   id;
  logic              hc;
  logic [CONN_W-1:0] conn;
  logic [TIME_W-1:0] tstamp;

  logic              hit;
  logic              free;
  logic [TIME_W-1:0] age;
  logic              ins_hit;
  logic              cmt_wr;

  always_comb begin
    hit     = tok.vld && valid && (id == tok.id);
    free    = tok.vld && (tok.op == OP_INS) && !valid && !tok.claimed;
    ins_hit = hit && (tok.op == OP_INS);
    age     = tok.tstamp - tstamp;
    cmt_wr  = commit.en && commit.wr && cand;

    tok_out         = tok;
    tok_out.matched = tok.matched | ins_hit;
    tok_out.claimed = tok.claimed | free;

    res      = '0;
    res.fire = tok.vld && (tok.op == OP_SCAN) && valid && hc && (age > timeout);
    if (res.fire) begin
      res.id   = id;
      res.conn = conn;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok <= '0;
    end else if (adv) begin
      tok <= tok_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      cand  <= 1'b0;
    end else if (commit.en) begin
      cand <= 1'b0;
      if (cmt_wr) begin
        valid <= 1'b1;
      end
    end else if (adv) begin
      // first free slot seen by an insert reserves itself
      if (free) begin
        cand <= 1'b1;
      end
      if (hit && (tok.op == OP_ERS)) begin
        valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmt_wr) begin
      id     <= commit.id;
      hc     <= commit.hc;
      conn   <= commit.conn;
      tstamp <= commit.tstamp;
    end else if (adv && ins_hit) begin
      hc     <= tok.hc;
      conn   <= tok.conn;
      tstamp <= tok.tstamp;
    end
  end

endmodule

[rtl/artt_row.sv]
// one table: a row of artt_cell slots with the token chained through them
// depends on artt_pkg and artt_cell
`timescale 1ns / 1ps

module artt_row #(
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     adv,
  input  logic [31:0]              timeout,
  input  artt_pkg::commit_t        commit,
  input  artt_pkg::tok_t           tok_in,
  output artt_pkg::tok_t           tail,
  output artt_pkg::res_t           res
);
  import artt_pkg::*;

  tok_t chain [0:DEPTH];
  res_t res_c [0:DEPTH-1];

  assign chain[0] = tok_in;
  assign tail     = chain[DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    artt_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .adv     (adv),
      .timeout (timeout),
      .commit  (commit),
      .tok_in  (chain[i]),
      .tok_out (chain[i+1]),
      .res     (res_c[i])
    );
  end

  // only the cell holding the scan token can drive a nonzero result
  always_comb begin
    res = '0;
    for (int i = 0; i < DEPTH; i++) begin
      res = res | res_c[i];
    end
  end

endmodule

[rtl/artt_chk.sv]
// port-level checker for the ack retransmit timeout tracker, bound to the top level
// depends on artt_pkg, assert_macros.svh and ack_retransmit_timeout_tracker_core
`timescale 1ns / 1ps
`include "assert_macros.svh"

module artt_chk (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tvalid,
  input logic                            s_tready,
  input logic [1:0]                      s_tuser,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [artt_pkg::M_TDATA_W-1:0]  m_tdata,
  input logic                            m_tuser,
  input logic                            m_tlast
);
  import artt_pkg::*;

  // a stalled result word holds
  `AST_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "result word changed while stalled")

  // a tick keeps the input closed while the tables are scanned
  `AST_NEXT(a_tick_busy, clk, rst, s_tvalid && s_tready && (s_tuser == MODE_TICK), !s_tready, "input reopened right after a tick")

  // results only appear while an item is being worked on
  `AST_SAME(a_rise_busy, clk, rst, $rose(m_tvalid), !$past(s_tready), "result appeared while idle")

  // within a tick, acks from the owed table never precede resends
  `AST_NEXT(a_order, clk, rst, m_tvalid && m_tready && !m_tlast && (m_tuser == ACT_ACK), !m_tvalid || (m_tuser == ACT_ACK), "resend after ack in one tick")

endmodule

bind ack_retransmit_timeout_tracker_core artt_chk u_artt_chk (.*);
